@@ rtl/b32e_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the base32 stream encoder.
// No dependencies.
package b32e_pkg;

    localparam int GROUP_BITS = 5;
    localparam int BYTE_BITS  = 8;
    localparam int MAX_SYMS   = 3;
    localparam int JOB_BITS   = GROUP_BITS * MAX_SYMS;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_DIGIT_2 = 8'h32;
    localparam logic [4:0] LETTER_COUNT = 5'd26;

    // one accepted byte, split into left-aligned symbol groups
    typedef struct packed {
        logic [JOB_BITS-1:0] groups;
        logic [1:0]          count;
        logic                last;
    } t_job;

    // RFC 4648 base32 alphabet: A..Z then 2..7
    function automatic logic [7:0] b32_char(input logic [4:0] v);
        logic [7:0] c;
        if (v < LETTER_COUNT) begin
            c = CHAR_UPPER_A + {3'b000, v};
        end else begin
            c = CHAR_DIGIT_2 + {3'b000, v - LETTER_COUNT};
        end
        return c;
    endfunction

endpackage

@@ rtl/b32e_front.sv @@
`timescale 1ns / 1ps
// Front end: joins leftover bits with the incoming byte and forms a job.
// Uses b32e_pkg.
module b32e_front
    import b32e_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_data_byte,
    input  logic       i_final_byte,
    output t_job       o_job
);

    logic [3:0]  r_holder, n_holder;
    logic [2:0]  r_held, n_held;
    logic [11:0] acc;
    logic [11:0] aligned;
    logic [3:0]  nbits;
    logic [3:0]  rem;
    logic        two_groups;

    always_comb begin
        acc        = {r_holder, i_data_byte};
        aligned    = acc << (3'd4 - r_held);
        nbits      = {1'b0, r_held} + 4'd8;
        two_groups = (nbits >= 4'd10);
        rem        = two_groups ? (nbits - 4'd10) : (nbits - 4'd5);

        o_job.groups = {aligned, 3'b000};
        o_job.count  = (two_groups ? 2'd2 : 2'd1) + {1'b0, (i_final_byte && rem != 4'd0)};
        o_job.last   = i_final_byte;

        n_holder = acc[3:0] & ((4'b0001 << rem) - 4'b0001);
        n_held   = rem[2:0];
        if (i_final_byte) begin
            n_holder = '0;
            n_held   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holder <= '0;
            r_held   <= '0;
        end else if (i_push) begin
            r_holder <= n_holder;
            r_held   <= n_held;
        end
    end

endmodule

@@ rtl/b32e_queue.sv @@
`timescale 1ns / 1ps
// Small job FIFO between front and back end.
// Uses b32e_pkg.
module b32e_queue
    import b32e_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  t_job                       i_job,
    input  logic                       i_pop,
    output t_job                       o_job,
    output logic                       o_nonempty,
    output logic                       o_full,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        logic [PW-1:0] q;
        if (p == PW'(DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + PW'(1);
        end
        return q;
    endfunction

    assign o_job      = r_mem[r_rd];
    assign o_nonempty = (r_cnt != '0);
    assign o_full     = (r_cnt == CW'(DEPTH));
    assign o_count    = r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

@@ rtl/b32e_back.sv @@
`timescale 1ns / 1ps
// Back end: walks the head job into the output register, one symbol per cycle
// while not stalled. Uses b32e_pkg.
module b32e_back
    import b32e_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_job,
    input  logic       i_job_valid,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_symbol_char,
    output logic [4:0] o_symbol_value,
    output logic       o_final_symbol
);

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_char;
    logic [4:0] r_value;
    logic       r_final;
    logic       advance, fire, last_sym;
    logic [4:0] sym;

    always_comb begin
        advance  = !r_valid || !i_stall;
        fire     = advance && i_job_valid;
        last_sym = (r_idx == i_job.count - 2'd1);
        case (r_idx)
            2'd0:    sym = i_job.groups[14:10];
            2'd1:    sym = i_job.groups[9:5];
            2'd2:    sym = i_job.groups[4:0];
            default: sym = '0;
        endcase
        o_pop = fire && last_sym;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (fire) begin
            r_valid <= 1'b1;
            r_idx   <= last_sym ? 2'd0 : r_idx + 2'd1;
        end else if (advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_char  <= b32_char(sym);
            r_value <= sym;
            r_final <= i_job.last && last_sym;
        end
    end

    assign o_valid        = r_valid;
    assign o_symbol_char  = r_char;
    assign o_symbol_value = r_value;
    assign o_final_symbol = r_final;

endmodule

@@ rtl/base32_stream_encoder.sv @@
`timescale 1ns / 1ps
// Top level of the base32 stream encoder (no '=' padding).
// Uses b32e_pkg, b32e_front, b32e_queue, b32e_back.
//
// Bytes enter MSB first and leave as RFC 4648 base32 characters, one symbol
// per beat, with the 5-bit group value alongside. A byte marked final flushes
// its leftover bits as a zero-padded group and tags the last symbol. The
// front takes a byte whenever the queue is not full and hands a job of one to
// three symbols to a QUEUE_DEPTH-entry queue; the back end drains it at one
// symbol per cycle while the output is not stalled, so the rate is set by the
// output port: a byte yields one or two symbols, two or three on a final
// byte. A beat is registered in the queue, then in the output register.
module base32_stream_encoder
    import b32e_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_final_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_symbol_char,
    output logic [4:0] o_symbol_value,
    output logic       o_final_symbol
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_job          front_job, head_job;
    logic          push, pop, q_nonempty, q_full;
    logic [CW-1:0] q_count;

    assign o_stall = q_full;
    assign push    = i_valid && !q_full;

    b32e_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .o_job        (front_job)
    );

    b32e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_job      (front_job),
        .i_pop      (pop),
        .o_job      (head_job),
        .o_nonempty (q_nonempty),
        .o_full     (q_full),
        .o_count    (q_count)
    );

    b32e_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (head_job),
        .i_job_valid    (q_nonempty),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_symbol_char  (o_symbol_char),
        .o_symbol_value (o_symbol_value),
        .o_final_symbol (o_final_symbol)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= CW'(QUEUE_DEPTH))
        else $error("job queue count above depth");

    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> q_count != '0)
        else $error("accepted beat left no job in queue");

    a_pop_has_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_nonempty && head_job.count != 2'd0)
        else $error("pop without a valid job");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && q_count == '0)
        else $error("output or queue busy after reset");

endmodule
